[hw/rtl/line_grid_block_walk_macros.svh]
// assertion macros for the grid block walk
`ifndef LINE_GRID_BLOCK_WALK_MACROS_SVH
`define LINE_GRID_BLOCK_WALK_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define LGBW_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define LGBW_ASSERT_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[hw/rtl/lgbw_pkg.sv]
// shared constants and control types for the grid block walk
`default_nettype none

package lgbw_pkg;

  // fixed field widths
  localparam int COORD_W    = 16;
  localparam int TAG_W      = 16;
  localparam int INDEX_W    = 10;
  localparam int DIM_W      = 6;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  // parameter defaults
  localparam int BLOCK_SHIFT_DEF  = 7;
  localparam int MAX_GRID_DIM_DEF = 32;
  localparam int MAX_WALK_DEF     = 64;

  // grid size after reset
  localparam logic [DIM_W-1:0] DIM_RESET = 6'd32;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ORIGIN_X  = 2'd0,
    CFG_ORIGIN_Y  = 2'd1,
    CFG_GRID_COLS = 2'd2,
    CFG_GRID_ROWS = 2'd3
  } cfg_index_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic prep;
    logic mult;
    logic init;
    logic step;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic in_range;
    logic stop;
  } dp_status_t;

endpackage

`default_nettype wire

[hw/rtl/lgbw_datapath.sv]
// datapath: block coordinates, decision term and walk step
`default_nettype none

module lgbw_datapath #(
  parameter int BLOCK_SHIFT  = lgbw_pkg::BLOCK_SHIFT_DEF,
  parameter int MAX_GRID_DIM = lgbw_pkg::MAX_GRID_DIM_DEF,
  parameter int MAX_WALK     = lgbw_pkg::MAX_WALK_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire lgbw_pkg::dp_cmd_t                     cmd,
  output      lgbw_pkg::dp_status_t                  status,
  input  wire logic signed [lgbw_pkg::COORD_W-1:0]   start_x,
  input  wire logic signed [lgbw_pkg::COORD_W-1:0]   start_y,
  input  wire logic signed [lgbw_pkg::COORD_W-1:0]   end_x,
  input  wire logic signed [lgbw_pkg::COORD_W-1:0]   end_y,
  input  wire logic        [lgbw_pkg::TAG_W-1:0]     segment_id,
  input  wire logic signed [lgbw_pkg::COORD_W-1:0]   origin_x,
  input  wire logic signed [lgbw_pkg::COORD_W-1:0]   origin_y,
  input  wire logic        [lgbw_pkg::DIM_W-1:0]     grid_cols,
  input  wire logic        [lgbw_pkg::DIM_W-1:0]     grid_rows,
  output      logic                                  valid,
  output      logic        [lgbw_pkg::INDEX_W-1:0]   block_index,
  output      logic        [lgbw_pkg::TAG_W-1:0]     segment_tag,
  output      logic                                  last,
  output      logic                                  reached_end
);

  localparam int RelW   = lgbw_pkg::COORD_W + 1;
  localparam int BlkW   = RelW - BLOCK_SHIFT;
  localparam int IdxW   = BlkW + lgbw_pkg::DIM_W + 2;
  localparam int MagW   = lgbw_pkg::COORD_W;
  localparam int ProdW  = BLOCK_SHIFT + MagW;
  localparam int DiffW  = ProdW + 2;
  localparam int TotW   = 2 * lgbw_pkg::DIM_W;
  localparam int CntW   = $clog2(MAX_WALK);
  localparam int DimMax = (1 << lgbw_pkg::DIM_W) - 1;
  localparam int DimCap = (MAX_GRID_DIM < DimMax) ? MAX_GRID_DIM : DimMax;

  localparam logic signed [DiffW-1:0]        DiffOne = DiffW'(1);
  localparam logic signed [IdxW-1:0]         IdxOne  = IdxW'(1);
  localparam logic [lgbw_pkg::DIM_W-1:0]     DimOne  = lgbw_pkg::DIM_W'(1);
  localparam logic [lgbw_pkg::DIM_W-1:0]     DimTop  = lgbw_pkg::DIM_W'(DimCap);
  localparam logic [CntW-1:0]                CntLast = CntW'(MAX_WALK - 1);

  // latched item
  logic signed [lgbw_pkg::COORD_W-1:0] px0, py0, px1, py1;
  logic        [lgbw_pkg::TAG_W-1:0]   tag;

  // prep stage registers
  logic [BLOCK_SHIFT-1:0]          tx, ty;
  logic [MagW-1:0]                 adx, ady;
  logic                            negx, negy;
  logic signed [BlkW-1:0]          bx, by, bex, bey;
  logic [lgbw_pkg::DIM_W-1:0]      cols, rows;

  // product stage registers
  logic [ProdW-1:0]                p1, p2;
  logic signed [IdxW-1:0]          b, bend;
  logic [TotW-1:0]                 tot;

  // walk registers
  logic signed [DiffW-1:0]         diff;
  logic [CntW-1:0]                 n;

  // prep combinational
  logic signed [RelW-1:0]          rel_x, rel_y, rel_ex, rel_ey, dlt_x, dlt_y;
  logic [BLOCK_SHIFT-1:0]          offx, offy;
  logic [lgbw_pkg::DIM_W-1:0]      cols_c, rows_c;

  // walk combinational
  logic signed [IdxW-1:0]          cols_e, b_next;
  logic signed [DiffW-1:0]         diff_next, ady_sh, adx_sh;
  logic                            hit, nb_in, step_col;

  // capture the item on accept
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px0 <= start_x;
      py0 <= start_y;
      px1 <= end_x;
      py1 <= end_y;
      tag <= segment_id;
    end
  end

  // relative coordinates, deltas and in-block offsets
  always_comb begin
    rel_x  = RelW'(px0) - RelW'(origin_x);
    rel_y  = RelW'(py0) - RelW'(origin_y);
    rel_ex = RelW'(px1) - RelW'(origin_x);
    rel_ey = RelW'(py1) - RelW'(origin_y);
    dlt_x  = RelW'(px1) - RelW'(px0);
    dlt_y  = RelW'(py1) - RelW'(py0);
    offx   = rel_x[BLOCK_SHIFT-1:0];
    offy   = rel_y[BLOCK_SHIFT-1:0];
  end

  // grid size clamp
  always_comb begin
    if (grid_cols == '0) begin
      cols_c = DimOne;
    end else if (grid_cols > DimTop) begin
      cols_c = DimTop;
    end else begin
      cols_c = grid_cols;
    end
    if (grid_rows == '0) begin
      rows_c = DimOne;
    end else if (grid_rows > DimTop) begin
      rows_c = DimTop;
    end else begin
      rows_c = grid_rows;
    end
  end

  // prep stage
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      negx <= dlt_x[RelW-1];
      negy <= dlt_y[RelW-1];
      adx  <= dlt_x[RelW-1] ? MagW'(-dlt_x) : MagW'(dlt_x);
      ady  <= dlt_y[RelW-1] ? MagW'(-dlt_y) : MagW'(dlt_y);
      tx   <= dlt_x[RelW-1] ? offx : ~offx;
      ty   <= dlt_y[RelW-1] ? offy : ~offy;
      bx   <= BlkW'(rel_x >>> BLOCK_SHIFT);
      by   <= BlkW'(rel_y >>> BLOCK_SHIFT);
      bex  <= BlkW'(rel_ex >>> BLOCK_SHIFT);
      bey  <= BlkW'(rel_ey >>> BLOCK_SHIFT);
      cols <= cols_c;
      rows <= rows_c;
    end
  end

  assign cols_e = $signed(IdxW'(cols));

  // product stage: decision products, end index, range size
  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      p1   <= ProdW'(tx) * ProdW'(ady);
      p2   <= ProdW'(ty) * ProdW'(adx);
      bend <= IdxW'(bey) * cols_e + IdxW'(bex);
      tot  <= TotW'(cols) * TotW'(rows);
    end
  end

  // walk step decode
  always_comb begin
    ady_sh    = $signed(DiffW'({ady, {BLOCK_SHIFT{1'b0}}}));
    adx_sh    = $signed(DiffW'({adx, {BLOCK_SHIFT{1'b0}}}));
    step_col  = diff[DiffW-1];
    hit       = (b == bend);
    if (step_col) begin
      b_next    = negx ? (b - IdxOne) : (b + IdxOne);
      diff_next = diff + ady_sh;
    end else begin
      b_next    = negy ? (b - cols_e) : (b + cols_e);
      diff_next = diff - adx_sh;
    end
    nb_in           = !b_next[IdxW-1] && ($unsigned(b_next) < IdxW'(tot));
    status.in_range = !b[IdxW-1] && ($unsigned(b) < IdxW'(tot));
    status.stop     = hit || (n == CntLast) || !nb_in;
  end

  // start index, decision term setup and walk update
  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      b <= IdxW'(by) * cols_e + IdxW'(bx);
    end else if (cmd.init) begin
      n <= '0;
      if (adx == '0) begin
        diff <= DiffOne;
      end else if (ady == '0) begin
        diff <= -DiffOne;
      end else begin
        diff <= $signed(DiffW'(p1)) - $signed(DiffW'(p2));
      end
    end else if (cmd.step) begin
      n    <= n + CntW'(1);
      b    <= b_next;
      diff <= diff_next;
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= cmd.step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      block_index <= b[lgbw_pkg::INDEX_W-1:0];
      segment_tag <= tag;
      last        <= status.stop;
      reached_end <= hit;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/lgbw_ctrl.sv]
// controller: sequences setup and walk of one segment
`default_nettype none

module lgbw_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output      logic                 busy,
  output      lgbw_pkg::dp_cmd_t    cmd,
  input  wire lgbw_pkg::dp_status_t status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MULT,
    S_INIT,
    S_WALK
  } state_t;

  state_t state, state_next;

  // command decode and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_MULT;
      end
      S_MULT: begin
        cmd.mult   = 1'b1;
        state_next = S_INIT;
      end
      S_INIT: begin
        cmd.init   = 1'b1;
        state_next = S_WALK;
      end
      S_WALK: begin
        cmd.step = status.in_range;
        if (!status.in_range || status.stop) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

[hw/rtl/line_grid_block_walk.sv]
// top level of the line segment grid block walk
//
// Usage: raise start with a segment on start_x/start_y/end_x/end_y and
// segment_id; the segment is taken at a rising edge where start is high and
// busy is low. The block then emits, one beat per cycle, the linear index of
// each grid block the segment touches, in walk order, each beat marked by
// valid for exactly one cycle. last marks the final beat of a segment and
// reached_end tells whether the walk hit the end block (0: left the grid or
// hit the walk cap). A segment whose start block index lies outside the
// grid's index range gives no beats at all.
// Timing: after the accept edge the block sets up the block coordinates,
// then the two decision products, then the decision term, and then emits
// one beat per cycle; busy stays high through setup and walk. The next
// segment is taken as soon as busy is low. The receiver cannot stall:
// beats are never held back.
// Configuration: cfg_we/cfg_index/cfg_data write origin_x, origin_y,
// grid_cols, grid_rows (indexes 0..3); the user must write them only while
// busy is low, which the block itself does not enforce.
// Reset (rst, synchronous): origin 0, grid 32 by 32, controller idle.
`default_nettype none

`include "line_grid_block_walk_macros.svh"

module line_grid_block_walk #(
  parameter int BLOCK_SHIFT  = lgbw_pkg::BLOCK_SHIFT_DEF,
  parameter int MAX_GRID_DIM = lgbw_pkg::MAX_GRID_DIM_DEF,
  parameter int MAX_WALK     = lgbw_pkg::MAX_WALK_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  output      logic                                  busy,
  input  wire logic signed [lgbw_pkg::COORD_W-1:0]   start_x,
  input  wire logic signed [lgbw_pkg::COORD_W-1:0]   start_y,
  input  wire logic signed [lgbw_pkg::COORD_W-1:0]   end_x,
  input  wire logic signed [lgbw_pkg::COORD_W-1:0]   end_y,
  input  wire logic        [lgbw_pkg::TAG_W-1:0]     segment_id,
  input  wire logic                                  cfg_we,
  input  wire logic        [lgbw_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  wire logic        [lgbw_pkg::CFG_DATA_W-1:0] cfg_data,
  output      logic                                  valid,
  output      logic        [lgbw_pkg::INDEX_W-1:0]   block_index,
  output      logic        [lgbw_pkg::TAG_W-1:0]     segment_tag,
  output      logic                                  last,
  output      logic                                  reached_end
);

  logic signed [lgbw_pkg::COORD_W-1:0] origin_x, origin_y;
  logic        [lgbw_pkg::DIM_W-1:0]   grid_cols, grid_rows;
  lgbw_pkg::dp_cmd_t                   cmd;
  lgbw_pkg::dp_status_t                status;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x  <= '0;
      origin_y  <= '0;
      grid_cols <= lgbw_pkg::DIM_RESET;
      grid_rows <= lgbw_pkg::DIM_RESET;
    end else if (cfg_we) begin
      unique case (lgbw_pkg::cfg_index_t'(cfg_index))
        lgbw_pkg::CFG_ORIGIN_X:  origin_x  <= $signed(cfg_data);
        lgbw_pkg::CFG_ORIGIN_Y:  origin_y  <= $signed(cfg_data);
        lgbw_pkg::CFG_GRID_COLS: grid_cols <= cfg_data[lgbw_pkg::DIM_W-1:0];
        lgbw_pkg::CFG_GRID_ROWS: grid_rows <= cfg_data[lgbw_pkg::DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // controller
  lgbw_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  // datapath
  lgbw_datapath #(
    .BLOCK_SHIFT  (BLOCK_SHIFT),
    .MAX_GRID_DIM (MAX_GRID_DIM),
    .MAX_WALK     (MAX_WALK)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .segment_id  (segment_id),
    .origin_x    (origin_x),
    .origin_y    (origin_y),
    .grid_cols   (grid_cols),
    .grid_rows   (grid_rows),
    .valid       (valid),
    .block_index (block_index),
    .segment_tag (segment_tag),
    .last        (last),
    .reached_end (reached_end)
  );

  // checks
  `LGBW_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted segment did not raise busy")
  `LGBW_ASSERT_IMP(a_beat_from_walk, valid, $past(busy), "beat without a walk in progress")
  `LGBW_ASSERT_IMP(a_last_ends_walk, valid && last, !busy, "walk still busy after last beat")
  `LGBW_ASSERT_IMP(a_end_on_last, valid && reached_end, last, "reached_end on a beat that is not last")

endmodule

`default_nettype wire
